// File: src/sbba_pkg.sv
package sbba_pkg;

	// request kinds carried in s_tuser
	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_BOOK    = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_RSVD    = 2'd3
	} mode_t;

	// result codes carried in m_tuser
	typedef enum logic [2:0] {
		STATUS_BOOKED   = 3'd0,
		STATUS_RELEASED = 3'd1,
		STATUS_INVALID  = 3'd2,
		STATUS_TAKEN    = 3'd3,
		STATUS_ABSENT   = 3'd4,
		STATUS_FULL     = 3'd5
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_LOAD = 6'b000100,
		ST_TEST = 6'b001000,
		ST_WR   = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	localparam int FIELD_W = 4;

endpackage

// File: src/slot_booking_bitmap_allocator.sv
// Room-by-slot booking allocator. The occupancy map holds one bit per (room, slot) pair,
// stored one room per word in a small RAM; per-room valid flops make the whole map read as
// free right after reset, so there is no clearing pass. A request beat carries the operation
// in s_tuser (allocate first free, book, release) and the 1-based room and slot in s_tdata;
// each request gives exactly one result beat with a status code in m_tuser and the 1-based
// room and slot of the affected entry in m_tdata (both zero on any error). One request is
// handled at a time and s_tready is high only while the sequencer is idle. Book and release
// put their result in the output register after the read, load, test and result states, with a
// write state between test and result when the map bit changes; an invalid request goes straight
// to the result state. Allocate tests one bit of the buffered room word per cycle and passes
// through the read and load states for each room on the single registered read port of the map
// RAM. The result state waits while the previous result still sits unaccepted in the output
// register, and the sequencer returns to idle as its result moves in. The next request may be
// accepted while the previous result still waits in the output register.
module slot_booking_bitmap_allocator
	import sbba_pkg::*;
#(
	parameter int NUM_ROOMS = 10,
	parameter int NUM_SLOTS = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // room [3:0], slot [7:4]
	input  logic [1:0] s_tuser,   // mode [1:0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // room_out [3:0], slot_out [7:4]
	output logic [2:0] m_tuser    // status [2:0]
);

	localparam int RIW = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
	localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [RIW-1:0] LAST_ROOM = RIW'(NUM_ROOMS - 1);
	localparam logic [SIW-1:0] LAST_SLOT = SIW'(NUM_SLOTS - 1);

	state_t                 state_q;
	mode_t                  mode_q;
	logic [RIW-1:0]         room_idx_q;   // 0-based room under work
	logic [SIW-1:0]         slot_idx_q;   // 0-based slot under work
	logic [NUM_SLOTS-1:0]   row_q;        // buffered room word
	logic [NUM_ROOMS-1:0]   row_vld_q;    // room word written since reset
	status_t                res_status_q;
	logic                   res_ok_q;     // result names an entry

	logic                   out_vld_q;
	status_t                out_status_q;
	logic [FIELD_W-1:0]     out_room_q;
	logic [FIELD_W-1:0]     out_slot_q;

	logic [NUM_SLOTS-1:0]   ram_rdata;
	logic [NUM_SLOTS-1:0]   row_now;
	logic                   ram_we;
	logic                   ram_re;
	logic                   accept;
	logic                   out_free;
	logic [FIELD_W-1:0]     in_room;
	logic [FIELD_W-1:0]     in_slot;
	mode_t                  in_mode;
	logic                   in_range_ok;
	logic                   cur_bit;

	assign in_room = s_tdata[3:0];
	assign in_slot = s_tdata[7:4];
	assign in_mode = mode_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// book and release need a real entry
	assign in_range_ok = (in_room != '0) && (in_room <= FIELD_W'(NUM_ROOMS))
		&& (in_slot != '0) && (in_slot <= FIELD_W'(NUM_SLOTS));

	// a room never written reads as all free
	assign row_now = row_vld_q[room_idx_q] ? ram_rdata : '0;
	assign cur_bit = row_q[slot_idx_q];

	assign ram_re = (state_q == ST_RD);
	assign ram_we = (state_q == ST_WR);

	sbba_ram #(
		.WIDTH (NUM_SLOTS),
		.DEPTH (NUM_ROOMS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (room_idx_q),
		.wdata (row_q),
		.re    (ram_re),
		.raddr (room_idx_q),
		.rdata (ram_rdata)
	);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_vld_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_mode == MODE_ALLOC) begin
							state_q <= ST_RD;
						end else if (in_mode == MODE_RSVD || !in_range_ok) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (mode_q == MODE_ALLOC) begin
						if (!cur_bit) begin
							state_q <= ST_WR;
						end else if (slot_idx_q == LAST_SLOT) begin
							state_q <= (room_idx_q == LAST_ROOM) ? ST_DONE : ST_RD;
						end
					end else if (mode_q == MODE_BOOK) begin
						state_q <= cur_bit ? ST_DONE : ST_WR;
					end else begin
						state_q <= cur_bit ? ST_WR : ST_DONE;
					end
				end
				ST_WR: begin
					row_vld_q[room_idx_q] <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q <= in_mode;
					res_ok_q <= 1'b0;
					res_status_q <= STATUS_INVALID;
					if (in_mode == MODE_ALLOC) begin
						room_idx_q <= '0;
						slot_idx_q <= '0;
					end else begin
						room_idx_q <= RIW'(in_room - 4'd1);
						slot_idx_q <= SIW'(in_slot - 4'd1);
					end
				end
			end
			ST_LOAD: begin
				row_q <= row_now;
			end
			ST_TEST: begin
				if (mode_q == MODE_ALLOC) begin
					if (!cur_bit) begin
						row_q[slot_idx_q] <= 1'b1;
						res_status_q <= STATUS_BOOKED;
						res_ok_q <= 1'b1;
					end else if (slot_idx_q == LAST_SLOT) begin
						slot_idx_q <= '0;
						if (room_idx_q == LAST_ROOM) begin
							res_status_q <= STATUS_FULL;
						end else begin
							room_idx_q <= room_idx_q + RIW'(1);
						end
					end else begin
						slot_idx_q <= slot_idx_q + SIW'(1);
					end
				end else if (mode_q == MODE_BOOK) begin
					if (cur_bit) begin
						res_status_q <= STATUS_TAKEN;
					end else begin
						row_q[slot_idx_q] <= 1'b1;
						res_status_q <= STATUS_BOOKED;
						res_ok_q <= 1'b1;
					end
				end else begin
					if (cur_bit) begin
						row_q[slot_idx_q] <= 1'b0;
						res_status_q <= STATUS_RELEASED;
						res_ok_q <= 1'b1;
					end else begin
						res_status_q <= STATUS_ABSENT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register: valid resets, payload loads when the result moves in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_room_q   <= res_ok_q ? FIELD_W'(room_idx_q) + 4'd1 : '0;
			out_slot_q   <= res_ok_q ? FIELD_W'(slot_idx_q) + 4'd1 : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_slot_q, out_room_q};

`ifndef ASSERT_OFF
	// an accepted request always leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after accept");

	// success codes name a real entry
	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STATUS_BOOKED || m_tuser == STATUS_RELEASED)
		|-> m_tdata[3:0] != 4'd0 && m_tdata[7:4] != 4'd0
		&& m_tdata[3:0] <= FIELD_W'(NUM_ROOMS) && m_tdata[7:4] <= FIELD_W'(NUM_SLOTS))
		else $error("success result without a valid entry");

	// error codes carry zero fields
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser == STATUS_BOOKED || m_tuser == STATUS_RELEASED)
		|-> m_tdata == 8'd0)
		else $error("error result with nonzero fields");

	// map writes stay inside the room and slot ranges
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> room_idx_q <= LAST_ROOM && slot_idx_q <= LAST_SLOT)
		else $error("map write out of range");

	// a write is always followed by the result stage
	a_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> state_q == ST_DONE)
		else $error("write not followed by result");
`endif

endmodule

// File: src/sbba_ram.sv
module sbba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
